>>> rtl/qet_pkg.sv
// Shared types and constants for the quoted escape tokenizer.
`timescale 1ns / 1ps

package qet_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HT     = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_END       = 2'd1,
    KIND_NOQUOTE   = 2'd2,
    KIND_BACKSLASH = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CLS_EOL,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_N,
    CLS_T,
    CLS_OCTAL,
    CLS_SPACE,
    CLS_OTHER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] char_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      out_kind;
    logic       last_of_run;
  } res_t;

endpackage

>>> rtl/qet_ifs.sv
// Valid/ready stream interfaces for the tokenizer's byte input and result output.
`timescale 1ns / 1ps

interface qet_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       line_end;

  modport source (output valid, output char_byte, output line_end, input ready);
  modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface qet_tok_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output out_kind, output last_of_run,
                  input ready);
  modport sink   (input valid, input out_byte, input out_kind, input last_of_run,
                  output ready);
endinterface

>>> rtl/qet_front.sv
// Front stage: accepts input bytes and classifies them into a registered item.
`timescale 1ns / 1ps

module qet_front import qet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qet_char_if.sink   chars,
  output logic       push_valid,
  output item_t      push_item,
  input  logic       push_ready
);

  logic  fvalid;
  item_t fitem;
  cls_t  cls_next;

  always_comb begin
    priority if (chars.line_end || chars.char_byte == 8'h00) begin
      cls_next = CLS_EOL;
    end else if (chars.char_byte == CH_QUOTE) begin
      cls_next = CLS_QUOTE;
    end else if (chars.char_byte == CH_BSLASH) begin
      cls_next = CLS_BSLASH;
    end else if (chars.char_byte == CH_N) begin
      cls_next = CLS_N;
    end else if (chars.char_byte == CH_T) begin
      cls_next = CLS_T;
    end else if (chars.char_byte >= CH_ZERO && chars.char_byte <= CH_SEVEN) begin
      cls_next = CLS_OCTAL;
    end else if (chars.char_byte == CH_SPACE ||
                 (chars.char_byte >= CH_HT && chars.char_byte <= CH_CR)) begin
      cls_next = CLS_SPACE;
    end else begin
      cls_next = CLS_OTHER;
    end
  end

  assign chars.ready = !fvalid || push_ready;
  assign push_valid  = fvalid;
  assign push_item   = fitem;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (chars.valid && chars.ready) begin
      fvalid          <= 1'b1;
      fitem.cls       <= cls_next;
      fitem.char_byte <= chars.char_byte;
    end else if (push_ready) begin
      fvalid <= 1'b0;
    end
  end

endmodule

>>> rtl/qet_fifo.sv
// Short queue of classified items between the front and back stages.
`timescale 1ns / 1ps

module qet_fifo import qet_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop
);

  item_t              slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = count != QCNT_W'(QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_item;
        wr_ptr        <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/qet_back.sv
// Back stage: tokenizer state machine and a two-entry result buffer on the output.
`timescale 1ns / 1ps

module qet_back import qet_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pop_valid,
  input  item_t     pop_item,
  output logic      pop,
  qet_tok_if.source tokens
);

  // Tokenizer state.
  logic       in_token, in_token_next;
  logic       in_quote, in_quote_next;
  logic       after_bs, after_bs_next;
  logic [1:0] oct_cnt, oct_cnt_next;
  logic [8:0] oct_val, oct_val_next;
  logic       err, err_next;

  // Results of one item.
  res_t       r0, r1;
  logic [1:0] nres;

  // Output register and the second buffered result behind it.
  logic out_valid, out_valid_next;
  res_t out_res, out_res_next;
  logic pend_valid, pend_valid_next;
  res_t pend_res, pend_res_next;
  logic drain;
  logic out_keep;
  logic pend_keep;

  logic [7:0] c;
  cls_t       cls;
  logic [8:0] oct_shift;
  logic [1:0] oct_cnt_inc;

  function automatic void put(inout res_t a, inout res_t b, inout logic [1:0] n,
                              input logic [7:0] val, input kind_t k);
    if (n == 2'd0) begin
      a.out_byte    = (k == KIND_BYTE) ? val : 8'h00;
      a.out_kind    = k;
      a.last_of_run = 1'b1;
    end else begin
      a.last_of_run = 1'b0;
      b.out_byte    = (k == KIND_BYTE) ? val : 8'h00;
      b.out_kind    = k;
      b.last_of_run = 1'b1;
    end
    n = n + 2'd1;
  endfunction

  assign c           = pop_item.char_byte;
  assign cls         = pop_item.cls;
  assign oct_shift   = {oct_val[5:0], 3'b000} | {6'd0, c[2:0]};
  assign oct_cnt_inc = oct_cnt + 2'd1;

  always_comb begin
    in_token_next = in_token;
    in_quote_next = in_quote;
    after_bs_next = after_bs;
    oct_cnt_next  = oct_cnt;
    oct_val_next  = oct_val;
    err_next      = err;
    r0            = '0;
    r1            = '0;
    nres          = 2'd0;
    if (cls == CLS_EOL) begin
      if (!err) begin
        if (oct_cnt != 2'd0) begin
          put(r0, r1, nres, oct_val[7:0], KIND_BYTE);
        end
        if (after_bs) begin
          put(r0, r1, nres, 8'h00, KIND_BACKSLASH);
        end else if (in_quote) begin
          put(r0, r1, nres, 8'h00, KIND_NOQUOTE);
        end else if (in_token) begin
          put(r0, r1, nres, 8'h00, KIND_END);
        end
      end
      // Every line end returns the tokenizer to its reset state.
      in_token_next = 1'b0;
      in_quote_next = 1'b0;
      after_bs_next = 1'b0;
      oct_cnt_next  = 2'd0;
      oct_val_next  = 9'd0;
      err_next      = 1'b0;
    end else if (!err) begin
      if (oct_cnt != 2'd0 && cls == CLS_OCTAL) begin
        if (oct_cnt_inc == 2'd3) begin
          put(r0, r1, nres, oct_shift[7:0], KIND_BYTE);
          oct_cnt_next = 2'd0;
          oct_val_next = 9'd0;
        end else begin
          oct_cnt_next = oct_cnt_inc;
          oct_val_next = oct_shift;
        end
      end else begin
        // A pending escape ended by a non-digit flushes its value first.
        if (oct_cnt != 2'd0) begin
          put(r0, r1, nres, oct_val[7:0], KIND_BYTE);
          oct_cnt_next = 2'd0;
          oct_val_next = 9'd0;
        end
        if (after_bs) begin
          after_bs_next = 1'b0;
          priority if (cls == CLS_N) begin
            put(r0, r1, nres, CH_LF, KIND_BYTE);
          end else if (cls == CLS_T) begin
            put(r0, r1, nres, CH_HT, KIND_BYTE);
          end else if (cls == CLS_OCTAL) begin
            oct_cnt_next = 2'd1;
            oct_val_next = {6'd0, c[2:0]};
          end else begin
            put(r0, r1, nres, c, KIND_BYTE);
          end
        end else begin
          priority if (cls == CLS_QUOTE) begin
            in_quote_next = !in_quote;
            in_token_next = 1'b1;
          end else if (cls == CLS_BSLASH && in_quote) begin
            after_bs_next = 1'b1;
          end else if (cls == CLS_SPACE && !in_quote) begin
            if (in_token) begin
              put(r0, r1, nres, 8'h00, KIND_END);
              in_token_next = 1'b0;
            end
          end else begin
            put(r0, r1, nres, c, KIND_BYTE);
            in_token_next = 1'b1;
          end
        end
      end
    end
  end

  // Buffer occupancy after this cycle's output transfer; an item is taken only when
  // all of its results fit behind what stays.
  assign drain     = out_valid && tokens.ready;
  assign out_keep  = drain ? pend_valid : out_valid;
  assign pend_keep = pend_valid && !drain;
  assign pop       = pop_valid && (nres == 2'd0 ||
                                   (nres == 2'd1 && !pend_keep) ||
                                   (nres == 2'd2 && !out_keep));

  always_comb begin
    out_valid_next  = out_keep;
    out_res_next    = drain ? pend_res : out_res;
    pend_valid_next = pend_keep;
    pend_res_next   = pend_res;
    if (pop && nres != 2'd0) begin
      if (!out_keep) begin
        out_valid_next = 1'b1;
        out_res_next   = r0;
        if (nres == 2'd2) begin
          pend_valid_next = 1'b1;
          pend_res_next   = r1;
        end
      end else begin
        pend_valid_next = 1'b1;
        pend_res_next   = r0;
      end
    end
  end

  assign tokens.valid       = out_valid;
  assign tokens.out_byte    = out_res.out_byte;
  assign tokens.out_kind    = out_res.out_kind;
  assign tokens.last_of_run = out_res.last_of_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token   <= 1'b0;
      in_quote   <= 1'b0;
      after_bs   <= 1'b0;
      oct_cnt    <= 2'd0;
      oct_val    <= 9'd0;
      err        <= 1'b0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pop) begin
        in_token <= in_token_next;
        in_quote <= in_quote_next;
        after_bs <= after_bs_next;
        oct_cnt  <= oct_cnt_next;
        oct_val  <= oct_val_next;
        err      <= err_next;
      end
      out_valid  <= out_valid_next;
      out_res    <= out_res_next;
      pend_valid <= pend_valid_next;
      pend_res   <= pend_res_next;
    end
  end

  a_pend_needs_out: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> out_valid)
    else $error("second result held without a result in the output register");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !(out_valid && tokens.ready) |=> pend_valid && $stable(pend_res))
    else $error("held second result lost while output stalled");

  a_oct_cnt_range: assert property (@(posedge clk) disable iff (rst)
    oct_cnt != 2'd3)
    else $error("octal digit count reached three without completing");

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    pop && cls == CLS_EOL |=> !in_token && !in_quote && !after_bs && oct_cnt == 2'd0)
    else $error("line end did not clear tokenizer state");

endmodule

>>> rtl/quoted_escape_tokenizer.sv
// Top level of the quoted string tokenizer with C-style escapes.
// Data path: classify register, queue, output register, then the result channel.
// Throughput: one input byte per cycle while the queue has room; the back stage takes
// one item per cycle while its results fit into a two-entry result buffer, which can
// take both results of an item (a flushed octal escape) at once; the four-entry queue
// absorbs stalls.
// Reset: synchronous active-high rst empties the queue and output slots and clears all
// tokenizer state; no clearing pass is needed.
`timescale 1ns / 1ps

module quoted_escape_tokenizer import qet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  qet_char_if.sink   chars,
  qet_tok_if.source  tokens
);

  // The front stage classifies each byte (line end, quote, backslash, escape letters,
  // octal digit, whitespace, other) and registers it.
  logic  push_valid;
  item_t push_item;
  logic  push_ready;

  // The back stage pulls classified items, runs the tokenizer state machine and
  // offers results one transfer per cycle while the result channel is ready.
  logic  pop_valid;
  item_t pop_item;
  logic  pop;

  qet_front u_front (
    .clk        (clk),
    .rst        (rst),
    .chars      (chars),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // The queue lets the input side keep moving while the output side stalls.
  qet_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  qet_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .tokens    (tokens)
  );

endmodule

>>> tb/quoted_escape_tokenizer_tb.sv
// Self-checking testbench for the quoted escape tokenizer, with its own token predictor.
`timescale 1ns / 1ps

module quoted_escape_tokenizer_tb import qet_pkg::*; ();

  // The watchdog gives up after this many cycles without a single transfer on either
  // channel. The slowest legal stretch (a 75% sender gap or a 75% receiver stall)
  // stays far below it.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles to keep watching after the last expected token, well past the pipeline of
  // the block, so that spurious extra results are still caught.
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 100;

  // One byte transfer on the input channel.
  typedef struct packed {
    logic [7:0] ch;
    logic       le;
  } char_xfer_t;

  logic clk;
  logic rst;

  qet_char_if chars_if ();
  qet_tok_if  tokens_if ();

  quoted_escape_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars_if),
    .tokens (tokens_if)
  );

  // Bytes waiting to be sent, and the tokenizer output that the accepted bytes must yield.
  char_xfer_t pending_chars[$];
  res_t       expected_tokens[$];

  // Idle percentages of the current traffic phase.
  int gap_pct;
  int stall_pct;

  int error_count;
  int quiet_cycles;
  int phase_items;
  int run_len;

  char_xfer_t next_char;
  res_t       got_token;
  res_t       want_token;

  // Predictor state. An error is only ever raised at a line end, and every line end
  // returns the tokenizer to its idle state, so there is never a window in which bytes
  // are ignored and no error flag has to be kept here.
  logic       tk_in_token;
  logic       tk_in_quote;
  logic       tk_escape;
  logic [1:0] tk_oct_cnt;
  logic [8:0] tk_oct_val;

  // ---------------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------------

  function automatic bit is_octal_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  // Queues one expected result of the current input byte. The byte field only carries
  // data for token bytes; every other kind shows zero there.
  function automatic void add_token(input logic [7:0] b, input kind_t kind);
    res_t r;
    r.out_byte    = (kind == KIND_BYTE) ? b : 8'h00;
    r.out_kind    = kind;
    r.last_of_run = 1'b0;
    expected_tokens.push_back(r);
    run_len++;
  endfunction

  // Ends a pending octal escape by emitting its value, cut to eight bits.
  function automatic void flush_octal();
    add_token(tk_oct_val[7:0], KIND_BYTE);
    tk_oct_cnt = 2'd0;
    tk_oct_val = 9'd0;
  endfunction

  // Handles a byte that is not part of a pending octal escape.
  function automatic void take_plain(input logic [7:0] c);
    if (tk_escape) begin
      tk_escape = 1'b0;
      if (c == CH_N) begin
        add_token(CH_LF, KIND_BYTE);
      end else if (c == CH_T) begin
        add_token(CH_HT, KIND_BYTE);
      end else if (is_octal_digit(c)) begin
        tk_oct_cnt = 2'd1;
        tk_oct_val = {6'd0, c[2:0]};
      end else begin
        add_token(c, KIND_BYTE);
      end
    end else if (c == CH_QUOTE) begin
      // A quote always opens a token, so that "" yields an empty one.
      tk_in_quote = !tk_in_quote;
      tk_in_token = 1'b1;
    end else if (c == CH_BSLASH && tk_in_quote) begin
      tk_escape = 1'b1;
    end else if (!tk_in_quote && (c == CH_SPACE || (c >= CH_HT && c <= CH_CR))) begin
      if (tk_in_token) begin
        add_token(8'h00, KIND_END);
        tk_in_token = 1'b0;
      end
    end else begin
      add_token(c, KIND_BYTE);
      tk_in_token = 1'b1;
    end
  endfunction

  // Works out every result that one accepted input byte causes and marks the last one.
  function automatic void predict_tokens(input logic [7:0] c, input logic le);
    res_t r;
    run_len = 0;
    if (le || c == 8'h00) begin
      if (tk_oct_cnt != 2'd0) flush_octal();
      if (tk_escape) begin
        add_token(8'h00, KIND_BACKSLASH);
      end else if (tk_in_quote) begin
        add_token(8'h00, KIND_NOQUOTE);
      end else if (tk_in_token) begin
        add_token(8'h00, KIND_END);
      end
      tk_in_token = 1'b0;
      tk_in_quote = 1'b0;
      tk_escape   = 1'b0;
      tk_oct_cnt  = 2'd0;
      tk_oct_val  = 9'd0;
    end else if (tk_oct_cnt != 2'd0) begin
      if (is_octal_digit(c)) begin
        tk_oct_val = {tk_oct_val[5:0], c[2:0]};
        tk_oct_cnt = tk_oct_cnt + 2'd1;
        // The third digit completes the escape right away.
        if (tk_oct_cnt == 2'd3) flush_octal();
      end else begin
        // Any other byte ends the escape and is then handled on its own.
        flush_octal();
        take_plain(c);
      end
    end else begin
      take_plain(c);
    end
    if (run_len != 0) begin
      r = expected_tokens.pop_back();
      r.last_of_run = 1'b1;
      expected_tokens.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------

  task automatic push_item(input logic [7:0] c, input logic le);
    char_xfer_t x;
    x.ch = c;
    x.le = le;
    pending_chars.push_back(x);
    phase_items++;
  endtask

  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  // A line ends either by the line end flag, with a random byte that must be ignored,
  // or by a zero byte.
  task automatic push_line_end();
    if ($urandom_range(0, 1) == 0) push_item(8'($urandom_range(0, 255)), 1'b1);
    else push_item(8'h00, 1'b0);
  endtask

  task automatic push_space();
    int n;
    int i;
    n = $urandom_range(1, 2);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) push_item(CH_SPACE, 1'b0);
      else push_item(8'($urandom_range(CH_HT, CH_CR)), 1'b0);
    end
  endtask

  // A byte that keeps a bare word going: no whitespace, no quote, no zero. Backslashes
  // and high bytes are allowed, since both are ordinary outside quotes.
  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE || c == CH_SPACE || (c >= CH_HT && c <= CH_CR))
      c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // A byte inside quotes that neither closes them nor starts an escape; whitespace is
  // allowed and must come out as token data.
  function automatic logic [7:0] quoted_byte();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_QUOTE || c == CH_BSLASH) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  task automatic push_octal(input int digits);
    int i;
    for (i = 0; i < digits; i++) push_item(8'($urandom_range(CH_ZERO, CH_SEVEN)), 1'b0);
  endtask

  task automatic push_escape();
    push_item(CH_BSLASH, 1'b0);
    case ($urandom_range(0, 3))
      0: push_item(CH_N, 1'b0);
      1: push_item(CH_T, 1'b0);
      2: push_octal($urandom_range(1, 3));
      default: push_item(8'($urandom_range(1, 255)), 1'b0);
    endcase
  endtask

  task automatic push_quoted();
    int n;
    int i;
    push_item(CH_QUOTE, 1'b0);
    n = $urandom_range(0, 5);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) push_escape();
      else push_item(quoted_byte(), 1'b0);
    end
    push_item(CH_QUOTE, 1'b0);
  endtask

  task automatic push_word();
    int n;
    int i;
    n = $urandom_range(1, 4);
    for (i = 0; i < n; i++) push_item(word_byte(), 1'b0);
  endtask

  // One random value line. Most lines are well formed: words and quoted strings with
  // escapes, separated by whitespace. Some end in an open quote, a dangling backslash
  // or an unfinished octal escape, and a few are raw noise.
  task automatic gen_line();
    int parts;
    int i;
    if ($urandom_range(0, 9) == 0) begin
      parts = $urandom_range(1, 12);
      for (i = 0; i < parts; i++)
        push_item(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    end else begin
      parts = $urandom_range(1, 5);
      if ($urandom_range(0, 3) == 0) push_space();
      for (i = 0; i < parts; i++) begin
        if (i != 0) push_space();
        case ($urandom_range(0, 2))
          0: push_word();
          1: push_quoted();
          default: begin
            // A quoted part glued to a bare word forms a single token.
            push_quoted();
            push_word();
          end
        endcase
      end
      if ($urandom_range(0, 1) == 0) push_space();
      case ($urandom_range(0, 7))
        0: begin
          push_item(CH_QUOTE, 1'b0);
          push_item(quoted_byte(), 1'b0);
        end
        1: begin
          push_item(CH_QUOTE, 1'b0);
          push_item(CH_BSLASH, 1'b0);
        end
        2: begin
          push_item(CH_QUOTE, 1'b0);
          push_item(CH_BSLASH, 1'b0);
          push_octal($urandom_range(1, 2));
        end
        default: ;
      endcase
    end
    push_line_end();
  endtask

  // Returns once every queued byte has been accepted and every expected token has come.
  task automatic wait_drained();
    while (pending_chars.size() != 0 || chars_if.valid || expected_tokens.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------------

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    chars_if.valid     = 1'b0;
    chars_if.char_byte = 8'h00;
    chars_if.line_end  = 1'b0;
    tokens_if.ready    = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------
  // Driver: offers the pending bytes and predicts the tokens of each accepted one.
  // A byte stays on the bus until it is taken; a gap is only inserted between bytes.
  // ---------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid     <= 1'b0;
      chars_if.char_byte <= 8'h00;
      chars_if.line_end  <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready)
        predict_tokens(chars_if.char_byte, chars_if.line_end);
      if (!chars_if.valid || chars_if.ready) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          next_char = pending_chars.pop_front();
          chars_if.valid     <= 1'b1;
          chars_if.char_byte <= next_char.ch;
          chars_if.line_end  <= next_char.le;
        end else begin
          chars_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and checks each token transfer
  // against the oldest expectation.
  // ---------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      tokens_if.ready <= 1'b0;
    end else begin
      tokens_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      if (tokens_if.valid && tokens_if.ready) begin
        got_token.out_byte    = tokens_if.out_byte;
        got_token.out_kind    = kind_t'(tokens_if.out_kind);
        got_token.last_of_run = tokens_if.last_of_run;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token: byte %02h kind %0d last %0b", $time,
                   got_token.out_byte, got_token.out_kind, got_token.last_of_run);
          error_count++;
        end else begin
          want_token = expected_tokens.pop_front();
          if (got_token !== want_token) begin
            $display("%0t: token mismatch: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                     $time, want_token.out_byte, want_token.out_kind,
                     want_token.last_of_run, got_token.out_byte, got_token.out_kind,
                     got_token.last_of_run);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Watchdog: a hang on either channel ends the run.
  // ---------------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (tokens_if.valid && tokens_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------

  initial begin
    int round;
    int phase;
    error_count  = 0;
    quiet_cycles = 0;
    phase_items  = 0;
    run_len      = 0;
    gap_pct      = 0;
    stall_pct    = 0;
    tk_in_token  = 1'b0;
    tk_in_quote  = 1'b0;
    tk_escape    = 1'b0;
    tk_oct_cnt   = 2'd0;
    tk_oct_val   = 9'd0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed line one: a backslash and a high byte as plain word bytes, a word ended
    // by a space, an empty quoted token ended by a tab, then inside quotes the newline
    // and tab escapes, a three-digit octal escape whose value overflows eight bits, a
    // two-digit escape ended by a letter (two results from one byte), and a one-digit
    // escape still open at a flagged line end (value byte, then missing quote).
    push_text("a\\");
    push_item(8'hFF, 1'b0);
    push_text(" \"\"\t\"\\n\\t\\777\\12x\\5");
    push_item("q", 1'b1);
    // A backslash left dangling inside quotes at a zero byte line end.
    push_text("\"\\");
    push_item(8'h00, 1'b0);
    // A bare word cut off by the line end.
    push_text("b");
    push_item(8'h00, 1'b0);
    wait_drained();

    // Random lines through the four traffic phases, twice over. Every phase starts only
    // after the previous one has fully drained, which also makes the sender pause until
    // no token is outstanding.
    for (round = 0; round < 2; round++) begin
      for (phase = 0; phase < 4; phase++) begin
        case (phase)
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 75; stall_pct = 0;  end
          2: begin gap_pct = 0;  stall_pct = 75; end
          default: begin gap_pct = 27; stall_pct = 27; end
        endcase
        phase_items = 0;
        while (phase_items < ITEMS_PER_PHASE) gen_line();
        wait_drained();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_tokens.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
